// ===== rtl/vbc_pkg.sv =====
package vbc_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W    = 16;
    localparam int DATA_W      = 20;             // filter state, |value| stays below 2^17
    localparam int OPD_W       = DATA_W + 2;     // filter multiplier operand
    localparam int COEF_W      = 16;
    localparam int PROD_W      = OPD_W + COEF_W;
    localparam int VM_W        = DATA_W + 1;     // magnitude of doubled filter output
    localparam int QW          = VM_W;           // quotient bits of the compression divide
    localparam int DIV_CNT_W   = $clog2(QW);
    localparam int WPROD_W     = VM_W + DATA_W;
    localparam int GAIN_W      = 9;
    localparam int GP_W        = VM_W + GAIN_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 33;
    localparam int QM_W        = GP_W + RECIP_W - RECIP_SHIFT;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;

    // Arithmetic constants
    localparam logic signed [COEF_W-1:0] HP_COEF        = 16'sd28320;
    localparam logic signed [COEF_W-1:0] LP_COEF        = 16'sd15899;
    localparam logic [PROD_W-1:0]        Q15_HALF       = PROD_W'(16384);
    localparam int                       Q15_SHIFT      = 15;
    localparam logic [DATA_W-1:0]        COMP_THRESHOLD = DATA_W'(6000);
    localparam int                       COMP_SHIFT     = 3;
    localparam int                       DECAY_SHIFT    = 11;
    // ceil(2^33 / 100): exact truncating divide by 100 for products below 2^30
    localparam logic [RECIP_W-1:0]       RECIP_100      = 27'd85899346;
    localparam logic [QM_W-1:0]          SAT_POS_MAG    = QM_W'(32767);
    localparam logic [QM_W-1:0]          SAT_NEG_MAG    = QM_W'(32768);
    localparam logic [GAIN_W-1:0]        GAIN_MIN       = 9'd10;
    localparam logic [GAIN_W-1:0]        GAIN_MAX       = 9'd400;
    localparam logic [GAIN_W-1:0]        GAIN_RESET     = 9'd100;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PERCENT  = 8'd1;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_HP1_MUL,
        OP_HP1_UPD,
        OP_HP2_MUL,
        OP_HP2_UPD,
        OP_LP1_MUL,
        OP_LP1_UPD,
        OP_LP2_MUL,
        OP_LP2_UPD,
        OP_PEAK,
        OP_COMP_MUL,
        OP_DIV_STEP,
        OP_DIV_TAKE,
        OP_GAIN_MUL,
        OP_RECIP_MUL,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HP1_MUL,
        ST_HP1_UPD,
        ST_HP2_MUL,
        ST_HP2_UPD,
        ST_LP1_MUL,
        ST_LP1_UPD,
        ST_LP2_MUL,
        ST_LP2_UPD,
        ST_PEAK,
        ST_COMP_MUL,
        ST_DIV,
        ST_DIV_TAKE,
        ST_GAIN_MUL,
        ST_RECIP_MUL,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic filter_on;
        logic over_threshold;
    } dp_status_t;

    // Q15 scale with rounding half away from zero
    function automatic logic signed [DATA_W-1:0] q15_round(input logic signed [PROD_W-1:0] p);
        logic              neg;
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] r;
        logic signed [DATA_W-1:0] rs;
        neg = p[PROD_W-1];
        mag = neg ? PROD_W'(-p) : PROD_W'(p);
        r   = (mag + Q15_HALF) >> Q15_SHIFT;
        rs  = signed'(r[DATA_W-1:0]);
        q15_round = neg ? -rs : rs;
    endfunction

endpackage

// ===== rtl/vbc_in_if.sv =====
interface vbc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vbc_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/vbc_out_if.sv =====
interface vbc_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vbc_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/vbc_cfg_if.sv =====
interface vbc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [vbc_pkg::CFG_INDEX_W-1:0]      index;
    logic [vbc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/vbc_datapath.sv =====
module vbc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vbc_pkg::dp_cmd_t                    cmd,
    output vbc_pkg::dp_status_t                 status,
    input  logic signed [vbc_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                                cfg_we,
    input  logic [vbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [vbc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [vbc_pkg::SAMPLE_W-1:0] out_sample
);
    import vbc_pkg::*;

    // config registers
    logic              fe_reg, fe_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;

    // filter state
    logic                       en_seen_reg, en_seen_next;
    logic signed [SAMPLE_W-1:0] prev_in_reg, prev_in_next;
    logic signed [DATA_W-1:0]   prev_s1_reg, prev_s1_next;
    logic signed [DATA_W-1:0]   hp1_reg, hp1_next;
    logic signed [DATA_W-1:0]   hp2_reg, hp2_next;
    logic signed [DATA_W-1:0]   lp1_reg, lp1_next;
    logic signed [DATA_W-1:0]   lp2_reg, lp2_next;
    logic [DATA_W-1:0]          peak_reg, peak_next;

    // working registers
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       vneg_reg, vneg_next;
    logic [VM_W-1:0]            vmag_reg, vmag_next;
    logic [DATA_W-1:0]          rem_reg, rem_next;
    logic [QW-1:0]              lo_reg, lo_next;
    logic [GP_W-1:0]            gp_reg, gp_next;
    logic [QM_W-1:0]            qmag_reg, qmag_next;
    logic signed [SAMPLE_W-1:0] sout_reg, sout_next;

    logic signed [OPD_W-1:0]           opd;
    logic signed [COEF_W-1:0]          coef;
    logic signed [PROD_W-1:0]          prod_mul;
    logic signed [DATA_W-1:0]          rounded;
    logic [SAMPLE_W-1:0]               x_mag_in;
    logic [DATA_W-1:0]                 lp2_mag;
    logic [DATA_W-1:0]                 decay;
    logic [DATA_W-1:0]                 wanted;
    logic [WPROD_W-1:0]                wprod;
    logic [DATA_W:0]                   div_trial;
    logic [DATA_W:0]                   div_diff;
    logic                              div_ge;
    logic [GP_W-1:0]                   gp_mul;
    logic [GP_W+RECIP_W-1:0]           recip_mul;
    logic [GAIN_W-1:0]                 gain_clamped;

    // shared filter multiplier operands
    always_comb
    begin
        opd  = '0;
        coef = HP_COEF;
        case (cmd.op)
            OP_HP1_MUL:
            begin
                opd  = OPD_W'(hp1_reg) + OPD_W'(x_reg) - OPD_W'(prev_in_reg);
                coef = HP_COEF;
            end
            OP_HP2_MUL:
            begin
                opd  = OPD_W'(hp2_reg) + OPD_W'(hp1_reg) - OPD_W'(prev_s1_reg);
                coef = HP_COEF;
            end
            OP_LP1_MUL:
            begin
                opd  = OPD_W'(hp2_reg) - OPD_W'(lp1_reg);
                coef = LP_COEF;
            end
            OP_LP2_MUL:
            begin
                opd  = OPD_W'(lp1_reg) - OPD_W'(lp2_reg);
                coef = LP_COEF;
            end
            default:
            begin
                opd  = '0;
                coef = HP_COEF;
            end
        endcase
    end

    assign prod_mul = PROD_W'(opd) * PROD_W'(coef);
    assign rounded  = q15_round(prod_reg);

    assign x_mag_in = in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : SAMPLE_W'(in_sample);
    assign lp2_mag  = lp2_reg[DATA_W-1] ? DATA_W'(-lp2_reg) : DATA_W'(lp2_reg);
    assign decay    = (peak_reg - lp2_mag) >> DECAY_SHIFT;

    // 8:1 above threshold: value * wanted / peak
    assign wanted    = COMP_THRESHOLD + ((peak_reg - COMP_THRESHOLD) >> COMP_SHIFT);
    assign wprod     = WPROD_W'(vmag_reg) * WPROD_W'(wanted);
    assign div_trial = {rem_reg, lo_reg[QW-1]};
    assign div_diff  = div_trial - {1'b0, peak_reg};
    assign div_ge    = div_trial >= {1'b0, peak_reg};

    assign gp_mul    = GP_W'(vmag_reg) * GP_W'(gain_reg);
    assign recip_mul = (GP_W+RECIP_W)'(gp_reg) * (GP_W+RECIP_W)'(RECIP_100);

    assign gain_clamped = (cfg_data < GAIN_MIN) ? GAIN_MIN :
                          (cfg_data > GAIN_MAX) ? GAIN_MAX : cfg_data;

    always_comb
    begin
        fe_next      = fe_reg;
        gain_next    = gain_reg;
        en_seen_next = en_seen_reg;
        prev_in_next = prev_in_reg;
        prev_s1_next = prev_s1_reg;
        hp1_next     = hp1_reg;
        hp2_next     = hp2_reg;
        lp1_next     = lp1_reg;
        lp2_next     = lp2_reg;
        peak_next    = peak_reg;
        x_next       = x_reg;
        prod_next    = prod_reg;
        vneg_next    = vneg_reg;
        vmag_next    = vmag_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        gp_next      = gp_reg;
        qmag_next    = qmag_reg;
        sout_next    = sout_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_ENABLE: fe_next   = cfg_data[0];
                REG_GAIN_PERCENT:  gain_next = gain_clamped;
                default: ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                x_next    = in_sample;
                vneg_next = in_sample[SAMPLE_W-1];
                vmag_next = VM_W'(x_mag_in);
                // mode change flushes the filters and the peak follower
                if (fe_reg != en_seen_reg)
                begin
                    prev_in_next = '0;
                    prev_s1_next = '0;
                    hp1_next     = '0;
                    hp2_next     = '0;
                    lp1_next     = '0;
                    lp2_next     = '0;
                    peak_next    = '0;
                    en_seen_next = fe_reg;
                end
            end
            OP_HP1_MUL, OP_HP2_MUL, OP_LP1_MUL, OP_LP2_MUL:
                prod_next = prod_mul;
            OP_HP1_UPD:
            begin
                hp1_next     = rounded;
                prev_in_next = x_reg;
            end
            OP_HP2_UPD:
            begin
                hp2_next     = rounded;
                prev_s1_next = hp1_reg;
            end
            OP_LP1_UPD:
                lp1_next = lp1_reg + rounded;
            OP_LP2_UPD:
                lp2_next = lp2_reg + rounded;
            OP_PEAK:
            begin
                peak_next = (lp2_mag > peak_reg) ? lp2_mag : peak_reg - decay;
                vneg_next = lp2_reg[DATA_W-1];
                vmag_next = {lp2_mag, 1'b0};
            end
            OP_COMP_MUL:
            begin
                rem_next = wprod[WPROD_W-1:QW];
                lo_next  = wprod[QW-1:0];
            end
            OP_DIV_STEP:
            begin
                rem_next = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
                lo_next  = {lo_reg[QW-2:0], div_ge};
            end
            OP_DIV_TAKE:
                vmag_next = lo_reg;
            OP_GAIN_MUL:
                gp_next = gp_mul;
            OP_RECIP_MUL:
                qmag_next = recip_mul[GP_W+RECIP_W-1:RECIP_SHIFT];
            OP_FINISH:
            begin
                if (vneg_reg)
                    sout_next = (qmag_reg > SAT_NEG_MAG) ? signed'(SAT_NEG_MAG[SAMPLE_W-1:0])
                                                         : -signed'(qmag_reg[SAMPLE_W-1:0]);
                else
                    sout_next = (qmag_reg > SAT_POS_MAG) ? signed'(SAT_POS_MAG[SAMPLE_W-1:0])
                                                         : signed'(qmag_reg[SAMPLE_W-1:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_reg      <= 1'b0;
            gain_reg    <= GAIN_RESET;
            en_seen_reg <= 1'b0;
            prev_in_reg <= '0;
            prev_s1_reg <= '0;
            hp1_reg     <= '0;
            hp2_reg     <= '0;
            lp1_reg     <= '0;
            lp2_reg     <= '0;
            peak_reg    <= '0;
        end
        else
        begin
            fe_reg      <= fe_next;
            gain_reg    <= gain_next;
            en_seen_reg <= en_seen_next;
            prev_in_reg <= prev_in_next;
            prev_s1_reg <= prev_s1_next;
            hp1_reg     <= hp1_next;
            hp2_reg     <= hp2_next;
            lp1_reg     <= lp1_next;
            lp2_reg     <= lp2_next;
            peak_reg    <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        prod_reg <= prod_next;
        vneg_reg <= vneg_next;
        vmag_reg <= vmag_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        gp_reg   <= gp_next;
        qmag_reg <= qmag_next;
        sout_reg <= sout_next;
    end

    assign status.filter_on      = fe_reg;
    assign status.over_threshold = peak_reg > COMP_THRESHOLD;
    assign out_sample            = sout_reg;

endmodule

// ===== rtl/vbc_ctrl.sv =====
module vbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  vbc_pkg::dp_status_t status,
    output vbc_pkg::dp_cmd_t    cmd
);
    import vbc_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 finish_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = OP_NONE;
        in_ready     = 1'b0;
        finish_fire  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = status.filter_on ? ST_HP1_MUL : ST_GAIN_MUL;
                end
            end
            ST_HP1_MUL:
            begin
                cmd.op     = OP_HP1_MUL;
                state_next = ST_HP1_UPD;
            end
            ST_HP1_UPD:
            begin
                cmd.op     = OP_HP1_UPD;
                state_next = ST_HP2_MUL;
            end
            ST_HP2_MUL:
            begin
                cmd.op     = OP_HP2_MUL;
                state_next = ST_HP2_UPD;
            end
            ST_HP2_UPD:
            begin
                cmd.op     = OP_HP2_UPD;
                state_next = ST_LP1_MUL;
            end
            ST_LP1_MUL:
            begin
                cmd.op     = OP_LP1_MUL;
                state_next = ST_LP1_UPD;
            end
            ST_LP1_UPD:
            begin
                cmd.op     = OP_LP1_UPD;
                state_next = ST_LP2_MUL;
            end
            ST_LP2_MUL:
            begin
                cmd.op     = OP_LP2_MUL;
                state_next = ST_LP2_UPD;
            end
            ST_LP2_UPD:
            begin
                cmd.op     = OP_LP2_UPD;
                state_next = ST_PEAK;
            end
            ST_PEAK:
            begin
                cmd.op     = OP_PEAK;
                state_next = ST_COMP_MUL;
            end
            ST_COMP_MUL:
            begin
                // peak is updated by now
                if (status.over_threshold)
                begin
                    cmd.op       = OP_COMP_MUL;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    state_next = ST_GAIN_MUL;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (div_cnt_reg == DIV_CNT_W'(QW - 1))
                    state_next = ST_DIV_TAKE;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_DIV_TAKE:
            begin
                cmd.op     = OP_DIV_TAKE;
                state_next = ST_GAIN_MUL;
            end
            ST_GAIN_MUL:
            begin
                cmd.op     = OP_GAIN_MUL;
                state_next = ST_RECIP_MUL;
            end
            ST_RECIP_MUL:
            begin
                cmd.op     = OP_RECIP_MUL;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op      = OP_FINISH;
                    finish_fire = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = finish_fire | (out_valid_reg & ~out_ready);
    assign out_valid      = out_valid_reg;

`ifndef SYNTH
    a_load_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_HP1_MUL || state_reg == ST_GAIN_MUL))
        else $error("load did not branch to filter or gain");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg <= DIV_CNT_W'(QW - 1)))
        else $error("divider count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=> (state_reg == ST_FINISH))
        else $error("pending result overwritten");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

// ===== rtl/voice_bandpass_compressor.sv =====
// Channel   | Dir | Payload                   | Transfer when
// ----------+-----+---------------------------+---------------------------
// capture   | in  | sample_in  s16            | capture.valid && capture.ready
// playback  | out | sample_out s16            | playback.valid && playback.ready
// cfg       | in  | index u8, data u9         | cfg.valid && cfg.ready (always ready)
//
// One sample in flight. From the input transfer to the result in the output register, the
// sample passes load, gain multiply, reciprocal multiply and finish with the filter off. Filtered,
// the four filter multiply/update pairs, the peak update and the threshold check come first; when
// compressing, the compression multiply, the 21-step restoring divide and the quotient take follow.
// A new sample is taken once the previous one has reached the output register, even if
// that result is still waiting; a stalled output holds the next result in its last state.
// Async active-low reset: filter off, gain 100, all filter state and peak zero.
// Config writes are taken in any cycle and are meant for an idle block.
module voice_bandpass_compressor (
    input  logic      clk,
    input  logic      rst_n,
    vbc_in_if.sink    capture,
    vbc_out_if.source playback,
    vbc_cfg_if.sink   cfg
);
    import vbc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // config port never stalls
    assign cfg.ready = 1'b1;

    // sequencer: walks one sample through the shared multiplier and divider
    vbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (capture.valid),
        .in_ready  (capture.ready),
        .out_valid (playback.valid),
        .out_ready (playback.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // filter state, peak follower, compression divide, gain and saturation
    vbc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (capture.sample_in),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .out_sample (playback.sample_out)
    );

endmodule
